### rtl/ccbe_pkg.sv
package ccbe_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WIDTH_W    = 6;
    localparam int unsigned SHIFT_W    = 5;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned MIN_WIDTH  = 8;

    localparam logic [CRC_W-1:0] RST_POLY     = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] RST_RPOLY    = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] RST_INIT     = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] RST_XOR_OUT  = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [WIDTH_W-1:0] RST_WIDTH  = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRC_WIDTH  = 8'd0,
        REG_POLYNOMIAL = 8'd1,
        REG_INIT_VALUE = 8'd2,
        REG_XOR_OUT    = 8'd3,
        REG_REFLECT    = 8'd4
    } cfg_idx_t;

    // Settings as the datapath consumes them, shaped for the active width
    typedef struct packed {
        logic               reflect;
        logic [SHIFT_W-1:0] shift;    // 32 minus active width
        logic [CRC_W-1:0]   mask;
        logic [CRC_W-1:0]   poly_al;  // polynomial aligned to bit 31
        logic [CRC_W-1:0]   rpoly;    // reflected polynomial, LSB aligned
        logic [CRC_W-1:0]   init;
        logic [CRC_W-1:0]   xout;
    } ccbe_ctl_t;

    function automatic logic [CRC_W-1:0] reverse32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++)
        begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

### rtl/ccbe_ifs.sv
interface ccbe_in_if;
    logic                         valid;
    logic                         ready;
    logic [ccbe_pkg::BYTE_W-1:0]  data_byte;
    logic                         start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface ccbe_out_if;
    logic                         valid;
    logic                         ready;
    logic [ccbe_pkg::CRC_W-1:0]   crc_out;

    modport source (output valid, output crc_out, input ready);
    modport sink   (input valid, input crc_out, output ready);
endinterface

interface ccbe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ccbe_pkg::CFG_IDX_W-1:0] index;
    logic [ccbe_pkg::CRC_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ccbe_cfg.sv
module ccbe_cfg (
    input  logic              clk,
    input  logic              rst_n,
    ccbe_cfg_if.sink          cfg,
    output ccbe_pkg::ccbe_ctl_t ctl
);
    import ccbe_pkg::*;

    logic [WIDTH_W-1:0] crc_width_reg;
    logic [CRC_W-1:0]   polynomial_reg;
    logic [CRC_W-1:0]   init_value_reg;
    logic [CRC_W-1:0]   xor_out_reg;
    logic               reflect_reg;

    ccbe_ctl_t          ctl_reg;
    ccbe_ctl_t          ctl_next;

    logic [WIDTH_W-1:0] act_width;
    logic [WIDTH_W-1:0] shift_full;
    logic [CRC_W-1:0]   poly_m;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_width_reg  <= RST_WIDTH;
            polynomial_reg <= RST_POLY;
            init_value_reg <= RST_INIT;
            xor_out_reg    <= RST_XOR_OUT;
            reflect_reg    <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CRC_WIDTH:  crc_width_reg  <= cfg.data[WIDTH_W-1:0];
                REG_POLYNOMIAL: polynomial_reg <= cfg.data;
                REG_INIT_VALUE: init_value_reg <= cfg.data;
                REG_XOR_OUT:    xor_out_reg    <= cfg.data;
                REG_REFLECT:    reflect_reg    <= cfg.data[0];
                default:        ; // drop writes to unknown registers
            endcase
        end
    end

    // Clamp the width, then pre-shape every setting for the byte datapath
    always_comb
    begin
        if (crc_width_reg < WIDTH_W'(MIN_WIDTH))
            act_width = WIDTH_W'(MIN_WIDTH);
        else if (crc_width_reg > WIDTH_W'(CRC_W))
            act_width = WIDTH_W'(CRC_W);
        else
            act_width = crc_width_reg;

        shift_full       = WIDTH_W'(CRC_W) - act_width;
        ctl_next.reflect = reflect_reg;
        ctl_next.shift   = shift_full[SHIFT_W-1:0];
        ctl_next.mask    = ALL_ONES >> ctl_next.shift;
        poly_m           = polynomial_reg & ctl_next.mask;
        ctl_next.poly_al = poly_m << ctl_next.shift;
        ctl_next.rpoly   = reverse32(poly_m) >> ctl_next.shift;
        ctl_next.init    = init_value_reg & ctl_next.mask;
        ctl_next.xout    = xor_out_reg & ctl_next.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.reflect <= 1'b1;
            ctl_reg.shift   <= '0;
            ctl_reg.mask    <= ALL_ONES;
            ctl_reg.poly_al <= RST_POLY;
            ctl_reg.rpoly   <= RST_RPOLY;
            ctl_reg.init    <= RST_INIT;
            ctl_reg.xout    <= RST_XOR_OUT;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign ctl = ctl_reg;

endmodule

### rtl/ccbe_core.sv
module ccbe_core (
    input  logic                clk,
    input  logic                rst_n,
    input  ccbe_pkg::ccbe_ctl_t ctl,
    ccbe_in_if.sink             in_ch,
    ccbe_out_if.source          out_ch
);
    import ccbe_pkg::*;

    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_start_reg;

    logic                out_valid_reg;
    logic [CRC_W-1:0]    out_crc_reg;
    logic [CRC_W-1:0]    crc_state_reg;

    logic                advance;
    logic [CRC_W-1:0]    base;
    logic [CRC_W-1:0]    refl_crc;
    logic [CRC_W-1:0]    norm_crc;
    logic [CRC_W-1:0]    crc_next;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg  <= in_ch.data_byte;
            s1_start_reg <= in_ch.start_req;
        end
    end

    // Eight shift steps of one byte, in both bit orders
    always_comb
    begin
        base = (s1_start_reg ? ctl.init : crc_state_reg) & ctl.mask;

        refl_crc = base ^ {{(CRC_W-BYTE_W){1'b0}}, s1_byte_reg};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (refl_crc[0])
                refl_crc = (refl_crc >> 1) ^ ctl.rpoly;
            else
                refl_crc = refl_crc >> 1;
        end

        // MSB-first runs with the register aligned to bit 31
        norm_crc = (base << ctl.shift) ^ {s1_byte_reg, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (norm_crc[CRC_W-1])
                norm_crc = (norm_crc << 1) ^ ctl.poly_al;
            else
                norm_crc = norm_crc << 1;
        end
        norm_crc = norm_crc >> ctl.shift;

        crc_next = (ctl.reflect ? refl_crc : norm_crc) & ctl.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            crc_state_reg <= ALL_ONES;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                crc_state_reg <= crc_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_crc_reg <= crc_next ^ ctl.xout;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.crc_out = out_crc_reg;

endmodule

### rtl/configurable_crc_byte_engine.sv
// Configurable CRC engine, one message byte per item.
// in_ch carries data_byte and start_req; start_req reloads the initial value
// before the byte is absorbed. out_ch returns one crc_out per input item:
// the running CRC XORed with the output XOR, zero above the active width.
// cfg writes width, polynomial, initial value, output XOR and reflect flag
// by index; cfg.ready is always high. Write only while no item is in flight.
// An accepted item passes the input register, then the result register, on
// its way to out_ch. Throughput is one item per cycle while out_ch is ready;
// the eight shift steps of a byte form one XOR network between the input
// register and the result register, and the running CRC updates in that
// same cycle so a back-to-back byte sees it at once.
// A setting passes its register, then the control register, before use.
// Reset: standard CRC-32 settings (width 32, 0x04C11DB7, reflected, init and
// output XOR all ones) and a running register of all ones.
// When out_ch stalls, the result holds, one more item waits in the input
// register, and in_ch.ready drops until the result is taken.
module configurable_crc_byte_engine (
    input  logic       clk,
    input  logic       rst_n,
    ccbe_in_if.sink    in_ch,
    ccbe_out_if.source out_ch,
    ccbe_cfg_if.sink   cfg
);
    import ccbe_pkg::*;

    ccbe_ctl_t ctl;

    ccbe_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctl   (ctl)
    );

    ccbe_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    a_out_in_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.crc_out & ~ctl.mask) == '0))
        else $error("crc_out has bits above the active width");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with an empty result register");

    // An empty result register fills only from an item taken at the input
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, 2))
        else $error("result appeared without an accepted item");

endmodule
